// ----- rtl/ctc_greedy_decoder_unit_assert.svh -----
// Assertion macros for the CTC greedy decoder.
`ifndef CTC_GREEDY_DECODER_UNIT_ASSERT_SVH
`define CTC_GREEDY_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cgd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CGD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cgd: next-cycle check failed");

`endif

// ----- rtl/cgd_pkg.sv -----
`default_nettype none

package cgd_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int MAX_STEPS_DEF   = 64;

    localparam int PROB_W     = 8;
    localparam int CLASS_W    = 7;
    localparam int CSET_W     = 8;
    localparam int CONF_W     = 8;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CLASS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 4'd1;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- rtl/cgd_divider.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cgd_divider
    import cgd_pkg::*;
#(
    parameter int NUM_W = 14,
    parameter int DEN_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quot,
    output t_div_stat             o_stat
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_num;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in behind the numerator bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_quot      = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- rtl/ctc_greedy_decoder_unit.sv -----
// CTC greedy decoder: one class probability word per accepted input.
// A character word is held in the pending register until the output register is free.
// Inputs that neither emit nor end the sequence are taken back to back; an emitting input
// stalls input until its word is loaded; a sequence end waits on the divider for the mean.
// Reset (synchronous, active low) clears the sequence state and restores blank 0, charset 96.
`default_nettype none
`include "ctc_greedy_decoder_unit_assert.svh"

module ctc_greedy_decoder_unit
    import cgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PROB_W-1:0]     i_prob,
    input  wire logic                  i_last_class,
    input  wire logic                  i_last_step,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_kind,
    output logic      [CLASS_W-1:0]    o_class_index,
    output logic                       o_unknown_char,
    output logic      [PROB_W-1:0]     o_char_prob,
    output logic      [CONF_W-1:0]     o_confidence,
    output logic      [CNT_W-1:0]      o_char_count,
    output logic                       o_last
);

    localparam int CW   = $clog2(MAX_CLASSES);
    localparam int CNTW = $clog2(MAX_CLASSES + 1);
    localparam int EW   = $clog2(MAX_STEPS + 1);
    localparam int SW   = PROB_W + EW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHAR = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_SUM  = 2'd3;

    logic [1:0]         r_state,      n_state;
    logic [CNTW-1:0]    r_cnt,        n_cnt;
    logic [PROB_W-1:0]  r_best_prob,  n_best_prob;
    logic [CW-1:0]      r_best_class, n_best_class;
    logic [CLASS_W-1:0] r_prev_class, n_prev_class;
    logic               r_prev_valid, n_prev_valid;
    logic [SW-1:0]      r_sum,        n_sum;
    logic [EW-1:0]      r_emit,       n_emit;
    logic [CLASS_W-1:0] r_blank;
    logic [CSET_W-1:0]  r_charset;

    logic [CLASS_W-1:0] r_pend_class;
    logic [PROB_W-1:0]  r_pend_prob;
    logic               r_pend_seq;

    logic               r_out_valid;

    logic               in_acc;
    logic               take;
    logic [PROB_W-1:0]  cur_prob;
    logic [CW-1:0]      cur_class;
    logic [CW+6:0]      cls_ext;
    logic [CLASS_W-1:0] idx;
    logic               emit;
    logic               out_free;
    logic               pend_load;
    logic               load_char;
    logic               load_sum;
    logic               div_start;
    logic [SW-1:0]      div_quot;
    t_div_stat          div_stat;
    logic [EW+6:0]      cnt_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Running argmax; positions past the class limit drop out.
    always_comb begin
        take      = (r_cnt < CNTW'(MAX_CLASSES)) && ((r_cnt == '0) || (i_prob > r_best_prob));
        cur_prob  = take ? i_prob : r_best_prob;
        cur_class = take ? r_cnt[CW-1:0] : r_best_class;
        cls_ext   = {7'b0, cur_class};
        idx       = cls_ext[CLASS_W-1:0];
        emit      = (idx != r_blank) && !(r_prev_valid && (idx == r_prev_class))
                    && (r_emit < EW'(MAX_STEPS));
        cnt_ext   = {7'b0, r_emit};
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_best_prob  = r_best_prob;
        n_best_class = r_best_class;
        n_prev_class = r_prev_class;
        n_prev_valid = r_prev_valid;
        n_sum        = r_sum;
        n_emit       = r_emit;
        pend_load    = 1'b0;
        load_char    = 1'b0;
        load_sum     = 1'b0;
        div_start    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_cnt < CNTW'(MAX_CLASSES)) begin
                        n_cnt = r_cnt + CNTW'(1);
                    end
                    n_best_prob  = cur_prob;
                    n_best_class = cur_class;
                    if (i_last_class) begin
                        n_cnt        = '0;
                        n_best_prob  = '0;
                        n_best_class = '0;
                        n_prev_class = idx;
                        n_prev_valid = 1'b1;
                        if (emit) begin
                            n_sum     = r_sum + SW'(cur_prob);
                            n_emit    = r_emit + EW'(1);
                            pend_load = 1'b1;
                            n_state   = S_CHAR;
                        end else if (i_last_step) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        if (i_last_step) begin
                            n_prev_class = '0;
                            n_prev_valid = 1'b0;
                        end
                    end
                end
            end
            S_CHAR: begin
                if (out_free) begin
                    load_char = 1'b1;
                    if (r_pend_seq) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    load_sum = 1'b1;
                    n_sum    = '0;
                    n_emit   = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_best_prob  <= '0;
            r_best_class <= '0;
            r_prev_class <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_emit       <= '0;
            r_blank      <= '0;
            r_charset    <= CSET_W'(96);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_best_prob  <= n_best_prob;
            r_best_class <= n_best_class;
            r_prev_class <= n_prev_class;
            r_prev_valid <= n_prev_valid;
            r_sum        <= n_sum;
            r_emit       <= n_emit;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BLANK_CLASS:  r_blank   <= i_cfg_data[CLASS_W-1:0];
                    CFG_CHARSET_SIZE: r_charset <= i_cfg_data[CSET_W-1:0];
                    default: ;
                endcase
            end
            if (load_char || load_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the character word until the output register frees up.
    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend_class <= idx;
            r_pend_prob  <= cur_prob;
            r_pend_seq   <= i_last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_char) begin
            o_kind         <= KIND_CHAR;
            o_class_index  <= r_pend_class;
            o_unknown_char <= {1'b0, r_pend_class} >= r_charset;
            o_char_prob    <= r_pend_prob;
            o_confidence   <= '0;
            o_char_count   <= '0;
            o_last         <= !r_pend_seq;
        end else if (load_sum) begin
            o_kind         <= KIND_SUMMARY;
            o_class_index  <= '0;
            o_unknown_char <= 1'b0;
            o_char_prob    <= '0;
            o_confidence   <= (r_emit == '0) ? '0 : div_quot[CONF_W-1:0];
            o_char_count   <= cnt_ext[CNT_W-1:0];
            o_last         <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    cgd_divider #(
        .NUM_W (SW),
        .DEN_W (EW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_emit),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    `CGD_ASSERT_IMP(a_emit_bound, i_clk, i_rst_n, 1'b1, r_emit <= EW'(MAX_STEPS))
    `CGD_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, div_stat.busy, r_state == S_DIV)
    `CGD_ASSERT_IMP(a_sum_is_last, i_clk, i_rst_n, o_out_valid && o_kind == KIND_SUMMARY, o_last)
    `CGD_ASSERT_NXT(a_seq_end_busy, i_clk, i_rst_n, in_acc && i_last_class && i_last_step, r_state != S_IDLE)

endmodule

`default_nettype wire
